FILE: rtl/core/fdaf_pkg.sv
// ============================================================================
// fdaf_pkg - shared constants and helpers for the decimal ASCII formatter
// Widths, ASCII codes, the divide-by-ten reciprocal and the power-of-ten table.
// ============================================================================
package fdaf_pkg;

    localparam int VALUE_W   = 64;
    localparam int CHAR_W    = 7;
    localparam int PLACES_W  = 4;

    // Character buffer: sign + 10 integer digits + dot + 9 fraction digits
    localparam int BUF_DEPTH = 21;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);
    localparam logic [BUF_AW-1:0] BUF_LAST = BUF_AW'(BUF_DEPTH - 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 7'h2E;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

    localparam logic [PLACES_W-1:0] PLACES_RESET = 4'd3;
    localparam logic [PLACES_W-1:0] PLACES_MAX   = 4'd9;

    localparam logic [31:0] INT_LIMIT = 32'h7FFF_FFFF;
    localparam logic [63:0] HALF_LSB  = 64'h0000_0000_8000_0000;

    // floor(v / 10) == (v * RECIP10) >> RECIP_SHIFT for every 32-bit v
    localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam int          QUOT_W      = 64 - RECIP_SHIFT;

    function automatic logic [31:0] pow10(input logic [PLACES_W-1:0] p);
        logic [31:0] r;
        unique case (p)
            4'd0:    r = 32'd1;
            4'd1:    r = 32'd10;
            4'd2:    r = 32'd100;
            4'd3:    r = 32'd1000;
            4'd4:    r = 32'd10000;
            4'd5:    r = 32'd100000;
            4'd6:    r = 32'd1000000;
            4'd7:    r = 32'd10000000;
            4'd8:    r = 32'd100000000;
            4'd9:    r = 32'd1000000000;
            default: r = 32'd1;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/fdaf_if.sv
// ============================================================================
// fdaf_if - request channels of the decimal ASCII formatter
// Input channel carries one Q31.32 value; output channel one character.
// ============================================================================
interface fdaf_in_if
    import fdaf_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface fdaf_out_if
    import fdaf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] text_char;
    logic              last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

FILE: rtl/core/fdaf_mul_unit.sv
// ============================================================================
// fdaf_mul_unit - shared 32x32 multiplier with divide-by-ten digit split
// Registered product; quotient and remainder digit follow from the product.
// ============================================================================
module fdaf_mul_unit
    import fdaf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [31:0]       i_op_a,
    input  logic [31:0]       i_op_b,
    input  logic [31:0]       i_dividend,   // value that produced the product
    output logic [63:0]       o_prod,
    output logic [QUOT_W-1:0] o_quot,
    output logic [3:0]        o_digit
);

    logic [63:0] r_prod;
    logic [3:0]  q_x10_lo;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_op_a * i_op_b;
        end
    end

    assign o_prod = r_prod;
    assign o_quot = r_prod[63:RECIP_SHIFT];

    // remainder is 0..9, so the low nibble of v - 10q is enough
    assign q_x10_lo = 4'({o_quot[0], 3'b000}) + 4'({o_quot[2:0], 1'b0});
    assign o_digit  = i_dividend[3:0] - q_x10_lo;

endmodule

FILE: rtl/core/fixed_decimal_ascii_formatter.sv
// ============================================================================
// fixed_decimal_ascii_formatter - Q31.32 to decimal ASCII text
// Prints a signed fixed-point value as ASCII characters, one per request.
// ============================================================================
// Usage:
//   i_in   : one request per number (signed Q31.32 in value).
//   o_out  : one request per character, last_char set on the final one.
//   i_cfg_wr_en / i_cfg_wr_data : decimal places (0..9, larger saturates to
//            9, reset 3); write only while the formatter is idle.
// Flow: a number is scaled and rounded, then its fraction digits (0..9),
//   a dot when places > 0, its integer digits (1..10) and, if negative, a
//   sign are written to the character buffer last-first, and a prime
//   product precedes each digit loop; the buffer is then drained to the output.
//   The shared multiplier peels off one decimal digit per cycle
//   (reciprocal multiply by 1/10), and the character buffer drains one
//   entry per cycle while the output is not stalled.
// Reset: returns to idle, output empty, places back to 3.
// Stall: the last character waits in the output register; a new number is
//   accepted while it waits. Earlier characters hold the buffer in place.
// ============================================================================
module fixed_decimal_ascii_formatter
    import fdaf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [PLACES_W-1:0] i_cfg_wr_data,
    fdaf_in_if.sink             i_in,
    fdaf_out_if.source          o_out
);

    typedef enum logic [3:0] {
        S_IDLE,     // waiting for a number
        S_MUL,      // fraction * 10^places into the multiplier
        S_FIX,      // rounding, carry, saturation
        S_PRIME,    // first divide-by-ten product
        S_FDIG,     // fraction digits, least significant first
        S_DOT,      // decimal point
        S_IDIG,     // integer digits, least significant first
        S_SIGN,     // leading minus
        S_OUT       // drain buffer to the output register
    } t_state;

    t_state              r_state;
    logic [PLACES_W-1:0] r_cfg_places;
    logic [PLACES_W-1:0] r_places;
    logic                r_neg;
    logic [63:0]         r_mag;
    logic [31:0]         r_v;        // current dividend of the digit loop
    logic [31:0]         r_ival;     // final integer part
    logic [PLACES_W-1:0] r_fcnt;     // fraction digits still to split
    logic                r_fphase;   // prime leads to fraction digits
    logic                r_started;  // nonzero fraction digit seen
    logic [BUF_AW-1:0]   r_wp;       // buffer fills from the top down
    logic [BUF_AW-1:0]   r_rd;
    logic                r_oval;
    logic [CHAR_W-1:0]   r_char;
    logic                r_olast;
    logic [CHAR_W-1:0]   r_buf [BUF_DEPTH];

    logic [PLACES_W-1:0] places_eff;
    logic [31:0]         op_a;
    logic [31:0]         op_b;
    logic                mul_en;
    logic [63:0]         prod;
    logic [QUOT_W-1:0]   quot;
    logic [3:0]          digit;
    logic [CHAR_W-1:0]   digit_char;

    logic [63:0]         round_sum;
    logic [31:0]         rint;
    logic [31:0]         rint_sat;
    logic [63:0]         frac_sum;
    logic [31:0]         rf;
    logic [31:0]         scale;
    logic                carry;
    logic [31:0]         ip_inc;
    logic                ip_sat;
    logic [31:0]         ip_fin;
    logic                fzero;

    logic                buf_we;
    logic [CHAR_W-1:0]   buf_wdata;
    logic                out_load;

    assign places_eff = (r_cfg_places > PLACES_MAX) ? PLACES_MAX : r_cfg_places;

    // Shared multiplier: rounding product first, then reciprocal of ten
    always_comb begin
        op_a   = r_v;
        op_b   = RECIP10;
        mul_en = 1'b0;
        unique case (r_state)
            S_MUL: begin
                op_a   = r_mag[31:0];
                op_b   = scale;
                mul_en = 1'b1;
            end
            S_PRIME: begin
                mul_en = 1'b1;
            end
            S_FDIG, S_IDIG: begin
                op_a   = 32'(quot);
                mul_en = 1'b1;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    fdaf_mul_unit u_mul (
        .i_clk      (i_clk),
        .i_en       (mul_en),
        .i_op_a     (op_a),
        .i_op_b     (op_b),
        .i_dividend (r_v),
        .o_prod     (prod),
        .o_quot     (quot),
        .o_digit    (digit)
    );

    assign digit_char = CHAR_ZERO + CHAR_W'(digit);

    // Rounding. Zero places: round the whole magnitude half away from zero.
    assign round_sum = r_mag + HALF_LSB;
    assign rint      = round_sum[63:32];
    assign rint_sat  = rint[31] ? INT_LIMIT : rint;

    // Otherwise: rf = (frac * 10^p + 1/2) >> 32, carry into integer on 10^p
    assign scale    = pow10(r_places);
    assign frac_sum = prod + HALF_LSB;
    assign rf       = frac_sum[63:32];
    assign carry    = (rf >= scale);
    assign ip_inc   = r_mag[63:32] + 32'(carry);
    assign ip_sat   = ip_inc[31];
    assign ip_fin   = ip_sat ? INT_LIMIT : ip_inc;
    assign fzero    = carry || ip_sat || (rf == 32'd0);

    // Buffer write: characters arrive last-first
    always_comb begin
        buf_we    = 1'b0;
        buf_wdata = digit_char;
        unique case (r_state)
            S_FIX: begin
                buf_we    = (r_places != '0) && fzero;
                buf_wdata = CHAR_ZERO;
            end
            S_FDIG: begin
                buf_we = r_started || (digit != 4'd0);   // strip trailing zeros
            end
            S_DOT: begin
                buf_we    = 1'b1;
                buf_wdata = CHAR_DOT;
            end
            S_IDIG: begin
                buf_we = 1'b1;
            end
            S_SIGN: begin
                buf_we    = 1'b1;
                buf_wdata = CHAR_MINUS;
            end
            default: begin
                buf_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (buf_we) begin
            r_buf[r_wp] <= buf_wdata;
        end
    end

    assign out_load = (r_state == S_OUT) && (!r_oval || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_oval       <= 1'b0;
            r_cfg_places <= PLACES_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg_places <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_oval  <= 1'b1;
                r_char  <= r_buf[r_rd];
                r_olast <= (r_rd == BUF_LAST);
                r_rd    <= r_rd + 1'b1;
            end else if (o_out.ready) begin
                r_oval <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_neg     <= i_in.value[VALUE_W-1];
                        r_mag     <= i_in.value[VALUE_W-1] ? 64'(-i_in.value)
                                                           : 64'(i_in.value);
                        r_places  <= places_eff;
                        r_wp      <= BUF_LAST;
                        r_started <= 1'b0;
                        r_state   <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_FIX;
                end
                S_FIX: begin
                    r_ival <= ip_fin;
                    if (r_places == '0) begin
                        r_v      <= rint_sat;
                        r_fphase <= 1'b0;
                        r_state  <= S_PRIME;
                    end else if (fzero) begin
                        r_wp    <= r_wp - 1'b1;
                        r_state <= S_DOT;
                    end else begin
                        r_v      <= rf;
                        r_fcnt   <= r_places;
                        r_fphase <= 1'b1;
                        r_state  <= S_PRIME;
                    end
                end
                S_PRIME: begin
                    r_state <= r_fphase ? S_FDIG : S_IDIG;
                end
                S_FDIG: begin
                    r_v    <= 32'(quot);
                    r_fcnt <= r_fcnt - 1'b1;
                    if (r_started || (digit != 4'd0)) begin
                        r_wp      <= r_wp - 1'b1;
                        r_started <= 1'b1;
                    end
                    if (r_fcnt == PLACES_W'(1)) begin
                        r_state <= S_DOT;
                    end
                end
                S_DOT: begin
                    r_wp     <= r_wp - 1'b1;
                    r_v      <= r_ival;
                    r_fphase <= 1'b0;
                    r_state  <= S_PRIME;
                end
                S_IDIG: begin
                    r_v  <= 32'(quot);
                    r_wp <= r_wp - 1'b1;
                    r_rd <= r_wp;
                    if (quot == '0) begin
                        r_state <= r_neg ? S_SIGN : S_OUT;
                    end
                end
                S_SIGN: begin
                    r_rd    <= r_wp;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load && (r_rd == BUF_LAST)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_oval;
    assign o_out.text_char = r_char;
    assign o_out.last_char = r_olast;

    // A stalled character holds still until the receiver takes it
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.text_char)
            && $stable(o_out.last_char))
        else $error("character changed while stalled");

    // Fraction digit loop never runs past its digit count
    a_fcnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FDIG) |-> (r_fcnt != '0))
        else $error("fraction digit loop with no digits left");

    // Integer part is saturated before digit splitting
    a_int_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRIME) && !r_fphase |-> !r_v[31])
        else $error("integer part above limit reached digit loop");

endmodule

FILE: verif/fdaf_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// fdaf_checker - character stream checker for the decimal ASCII formatter
// Tracks the places register, predicts the text of every accepted number and
// compares each character request against the oldest predicted character.
// ============================================================================
module fdaf_checker
    import fdaf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [PLACES_W-1:0] i_cfg_wr_data,
    fdaf_in_if                  i_in,
    fdaf_out_if                 i_out,
    output int                  o_mismatch_count,
    output int                  o_pending
);

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              last_char;
    } t_char_req;

    t_char_req           expected_chars[$];
    logic [PLACES_W-1:0] places_reg     = PLACES_RESET;
    int                  mismatch_count = 0;

    // Builds the text of one number and queues it, last flag on the final char.
    function automatic void format_value(input logic [VALUE_W-1:0] raw,
                                         input logic [PLACES_W-1:0] places);
        logic [63:0]       mag;
        logic [63:0]       ipart;
        logic [63:0]       scale;
        logic [63:0]       rf;
        logic [63:0]       int_val;
        logic [CHAR_W-1:0] text[$];
        logic [CHAR_W-1:0] int_digits[$];
        logic [CHAR_W-1:0] frac_digits[9];
        int                p;
        int                last_nz;
        int                k;
        bit                zero_frac;

        mag       = raw[63] ? -raw : raw;
        p         = (places > PLACES_MAX) ? int'(PLACES_MAX) : int'(places);
        zero_frac = 1'b0;
        rf        = '0;
        if (raw[63])
            text.push_back(CHAR_MINUS);

        if (p == 0) begin
            int_val = (mag + HALF_LSB) >> 32;
            if (int_val > INT_LIMIT)
                int_val = INT_LIMIT;
        end else begin
            ipart = mag >> 32;
            scale = 64'd1;
            repeat (p) scale = scale * 64'd10;
            rf = ({32'd0, mag[31:0]} * scale + HALF_LSB) >> 32;
            zero_frac = (rf == 0);
            if (rf >= scale) begin
                ipart     = ipart + 64'd1;
                zero_frac = 1'b1;
            end
            if (ipart > INT_LIMIT) begin
                ipart     = INT_LIMIT;
                zero_frac = 1'b1;
            end
            int_val = ipart;
        end

        do begin
            int_digits.push_front(CHAR_ZERO + CHAR_W'(int_val % 64'd10));
            int_val = int_val / 64'd10;
        end while (int_val != 0);
        foreach (int_digits[i])
            text.push_back(int_digits[i]);

        if (p != 0) begin
            text.push_back(CHAR_DOT);
            if (zero_frac) begin
                text.push_back(CHAR_ZERO);
            end else begin
                for (k = p - 1; k >= 0; k--) begin
                    frac_digits[k] = CHAR_ZERO + CHAR_W'(rf % 64'd10);
                    rf = rf / 64'd10;
                end
                last_nz = 0;
                for (k = 0; k < p; k++)
                    if (frac_digits[k] != CHAR_ZERO)
                        last_nz = k;
                for (k = 0; k <= last_nz; k++)
                    text.push_back(frac_digits[k]);
            end
        end

        foreach (text[i])
            expected_chars.push_back('{text[i], (i == text.size() - 1)});
    endfunction

    always @(posedge i_clk) begin
        t_char_req exp_char;
        if (!i_rst_n) begin
            expected_chars.delete();
            places_reg = PLACES_RESET;
        end else begin
            if (i_cfg_wr_en)
                places_reg = i_cfg_wr_data;
            if (i_in.valid && i_in.ready)
                format_value(i_in.value, places_reg);
            if (i_out.valid && i_out.ready) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected character request: text_char %h last_char %b",
                           i_out.text_char, i_out.last_char);
                    mismatch_count++;
                end else begin
                    exp_char = expected_chars.pop_front();
                    if (exp_char.text_char !== i_out.text_char) begin
                        $error("text_char: expected %h, actual %h",
                               exp_char.text_char, i_out.text_char);
                        mismatch_count++;
                    end
                    if (exp_char.last_char !== i_out.last_char) begin
                        $error("last_char: expected %b, actual %b",
                               exp_char.last_char, i_out.last_char);
                        mismatch_count++;
                    end
                end
            end
        end
        o_mismatch_count <= mismatch_count;
        o_pending        <= expected_chars.size();
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top - testbench for the fixed-point decimal ASCII formatter
// Drives signed Q31.32 numbers under several place settings, stalls the
// character stream at random and lets fdaf_checker verify every character.
// ============================================================================
module tb_top;
    import fdaf_pkg::*;

    // Settle time after the last character; covers a number still in flight.
    localparam int DRAIN_CYCLES = 60;
    // Hard stop: far beyond the slowest legal run (21 chars, long stalls).
    localparam int TIMEOUT_NS   = 20_000_000;

    // Directed numbers: zero, both extremes, sign-only zero, half rounding,
    // carry of the fraction into the integer, padding and trailing zeros,
    // the integer limit and a negative value that saturates when rounded to 0 places.
    localparam logic [VALUE_W-1:0] DIRECTED_VALUES [12] = '{
        64'h0000_0000_0000_0000,
        64'h8000_0000_0000_0000,
        64'h7FFF_FFFF_FFFF_FFFF,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'h0000_0000_8000_0000,
        64'hFFFF_FFFF_8000_0000,
        64'h0000_0000_FFFF_FFFF,
        64'h0000_0001_0000_0000,
        64'h0000_0000_0041_8938,
        64'h0000_0005_4000_0000,
        64'h7FFF_FFFF_0000_0000,
        64'h8000_0000_4000_0000
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                cfg_wr_en;
    logic [PLACES_W-1:0] cfg_wr_data;
    logic [PLACES_W-1:0] cur_places = PLACES_RESET;
    int unsigned         rx_cycle   = 0;
    int                  mismatch_count;
    int                  pending;

    fdaf_in_if  in_ch ();
    fdaf_out_if out_ch ();

    fixed_decimal_ascii_formatter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (in_ch),
        .o_out         (out_ch)
    );

    fdaf_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_wr_data    (cfg_wr_data),
        .i_in             (in_ch),
        .i_out            (out_ch),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver back-pressure: four modes in rotation, selected by rx_cycle[8:7] -
    // always ready, coin flip, ready only when rx_cycle[2:0] is zero, and long
    // stalls with ready only when rx_cycle[4:0] is 24 or more.
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        case (rx_cycle[8:7])
            2'd0:    out_ch.ready <= 1'b1;
            2'd1:    out_ch.ready <= 1'($urandom_range(0, 1));
            2'd2:    out_ch.ready <= (rx_cycle[2:0] == 3'd0);
            default: out_ch.ready <= (rx_cycle[4:0] >= 5'd24);
        endcase
    end

    // Holds one request on the input until the formatter takes it. Called and
    // returns at a rising edge, so back-to-back calls keep valid high.
    task automatic send_number(input logic [VALUE_W-1:0] number);
        in_ch.valid <= 1'b1;
        in_ch.value <= number;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Stops sending and waits until every predicted character has come out,
    // then lets the formatter settle. Register writes only follow this.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_places(input logic [PLACES_W-1:0] places);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= places;
        cur_places   = places;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        logic [PLACES_W-1:0] phase_places[8];
        logic [VALUE_W-1:0]  next_value;
        logic [63:0]         scale;
        logic [63:0]         k_val;
        logic [63:0]         frac64;
        logic [31:0]         frac;
        int unsigned         burst_left;
        int unsigned         gap;
        int unsigned         kind;
        int unsigned         p_eff;

        // Everything known from time zero; reset held, then released.
        i_rst_n      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        in_ch.valid  = 1'b0;
        in_ch.value  = '0;
        out_ch.ready = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset setting (3 places), then at 0 places
        // (integer rounding, saturation) and at 15, which saturates to 9.
        foreach (DIRECTED_VALUES[i])
            send_number(DIRECTED_VALUES[i]);
        wait_idle();
        write_places(4'd0);
        for (int i = 0; i < 7; i++)
            send_number(DIRECTED_VALUES[i]);
        wait_idle();
        write_places(4'd15);
        for (int i = 6; i < 12; i++)
            send_number(DIRECTED_VALUES[i]);
        wait_idle();

        // Random part: eight phases, each under its own places setting.
        phase_places[0] = 4'd0;
        phase_places[1] = 4'd9;
        phase_places[2] = 4'd15;
        phase_places[3] = 4'd1;
        for (int i = 4; i < 8; i++)
            phase_places[i] = PLACES_W'($urandom_range(0, 15));

        foreach (phase_places[ph]) begin
            write_places(phase_places[ph]);
            p_eff      = (cur_places > PLACES_MAX) ? PLACES_MAX : cur_places;
            burst_left = 0;
            repeat (45) begin
                // Bursts of 1..10 numbers; a zero gap chains two bursts.
                if (burst_left == 0) begin
                    gap = $urandom_range(0, 7);
                    if (gap != 0) begin
                        in_ch.valid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                    burst_left = $urandom_range(1, 10);
                end

                kind = $urandom_range(0, 9);
                case (kind)
                    0, 1, 2: next_value = {$urandom, $urandom};
                    3, 4, 5: next_value = {32'($urandom_range(0, 999)), 32'($urandom)};
                    6: begin
                        // Fraction right at a rounding step of the current
                        // setting; the top step is the carry into the integer.
                        scale = 64'd1;
                        repeat (p_eff) scale = scale * 64'd10;
                        k_val  = {$urandom, $urandom} % scale + 64'd1;
                        frac64 = ((k_val << 32) - HALF_LSB) / scale;
                        frac   = frac64[31:0] + 32'($urandom_range(0, 4)) - 32'd2;
                        next_value = {32'($urandom_range(0, 99)), frac};
                    end
                    7: next_value = {32'($urandom_range(0, 99)),
                                     ~32'($urandom_range(0, 1 << $urandom_range(0, 28)))};
                    8: next_value = {INT_LIMIT - 32'($urandom_range(0, 2)), 32'($urandom)};
                    // few fraction bits: trailing zeros get stripped
                    default: next_value = {32'($urandom_range(0, 99999)),
                                           4'($urandom), 28'd0};
                endcase
                if (kind >= 3 && $urandom_range(0, 1) == 1)
                    next_value = -next_value;

                send_number(next_value);
                burst_left--;
            end
            // Full pause until the stream is empty before the next setting.
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb_top failed");
        $finish;
    end

endmodule

FILE: fixed_decimal_ascii_formatter.f
rtl/core/fdaf_pkg.sv
rtl/core/fdaf_if.sv
rtl/core/fdaf_mul_unit.sv
rtl/core/fixed_decimal_ascii_formatter.sv
verif/fdaf_checker.sv
verif/tb_top.sv
